// File: hdl/pwlc_pkg.sv
// Shared types, constants and helpers for the piecewise linear calibration block.
`timescale 1ns / 1ps

package pwlc_pkg;

    // Table capacity and raw value width.
    localparam int MAX_POINTS  = 16;
    localparam int SAMPLE_BITS = 16;
    localparam int MIN_POINTS  = 2;

    // Raw values keep at most the 16 bits of their fields.
    localparam int RAW_BITS  = (SAMPLE_BITS < 16) ? SAMPLE_BITS : 16;
    localparam int FIELD_W   = 16;
    localparam int ENTRY_W   = 2 * FIELD_W;
    localparam int IDX_BITS  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_BITS  = $clog2(MAX_POINTS + 1);
    localparam int INDEX_W   = 4;
    localparam int POINTS_W  = 5;

    // Interpolation datapath widths.
    localparam int DIFF_W    = FIELD_W + 1;
    localparam int PROD_W    = 2 * DIFF_W;
    localparam int DIV_BITS  = PROD_W - 1;
    localparam int CORR_W    = 35;
    localparam int STATUS_W  = 2;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = POINTS_W;
    localparam logic [CFG_IDX_W-1:0] CFG_POINTS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTRAP = 2'd1;

    // Request kinds.
    localparam logic REQ_CONVERT = 1'b0;
    localparam logic REQ_WRITE   = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FEW        = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_RISING = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NUMERIC    = 2'd3;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_CALC,
        S_DIV_START,
        S_DIV_WAIT,
        S_FINISH
    } t_state;

    // Sign-extend the low RAW_BITS bits of a raw field to the full field width.
    function automatic logic signed [FIELD_W-1:0] sext_raw(input logic [FIELD_W-1:0] v);
        return FIELD_W'($signed(v[RAW_BITS-1:0]));
    endfunction

endpackage

// File: hdl/pwlc_ram.sv
// Generic single-port RAM with a registered read.
`timescale 1ns / 1ps

module pwlc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [WIDTH-1:0]  i_wdata,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write when enabled; read the addressed word every cycle.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/pwlc_div.sv
// Restoring unsigned divider that retires one quotient bit per cycle.
`timescale 1ns / 1ps

module pwlc_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [pwlc_pkg::DIV_BITS-1:0]    i_dividend,
    input  logic [pwlc_pkg::DIFF_W-1:0]      i_divisor,
    output logic                             o_done,
    output logic [pwlc_pkg::DIV_BITS-1:0]    o_quotient
);

    import pwlc_pkg::*;

    localparam int DCNT_W = $clog2(DIV_BITS + 1);

    logic                r_busy;
    logic                r_done;
    logic [DCNT_W-1:0]   r_cnt;
    logic [DIV_BITS-1:0] r_quo;
    logic [DIFF_W-1:0]   r_rem;
    logic [DIFF_W-1:0]   r_dsr;

    logic [DIFF_W:0]     shifted;
    logic [DIFF_W+1:0]   diff;
    logic                borrow;

    // Trial subtraction of the divisor from the shifted partial remainder.
    assign shifted = {r_rem, r_quo[DIV_BITS-1]};
    assign diff    = {1'b0, shifted} - {2'b00, r_dsr};
    assign borrow  = diff[DIFF_W+1];

    // Control: count the steps and flag the last one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (i_start) begin
                r_busy <= 1'b1;
                r_done <= 1'b0;
                r_cnt  <= DCNT_W'(DIV_BITS - 1);
            end else if (r_busy) begin
                r_done <= (r_cnt == '0);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    // Datapath: the dividend shifts out as the quotient shifts in.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            if (borrow) begin
                r_rem <= shifted[DIFF_W-1:0];
                r_quo <= {r_quo[DIV_BITS-2:0], 1'b0};
            end else begin
                r_rem <= diff[DIFF_W-1:0];
                r_quo <= {r_quo[DIV_BITS-2:0], 1'b1};
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// File: hdl/piecewise_linear_calibration.sv
// Top level of the piecewise linear calibration block: sequencer, table scan and output stage.
//
//   Channel   Direction  Handshake            Payload
//   request   in         i_valid / o_stall    i_req_type, i_entry_index, i_entry_raw,
//                                             i_entry_reference, i_sample_raw
//   result    out        o_valid / i_stall    o_corrected, o_status
//   config    in         i_cfg_we             i_cfg_index, i_cfg_data
//
// A point write goes from idle straight to the finish state, as does a convert with too few points;
// otherwise the scan reads one table entry per cycle from the single RAM port, over the n points in use.
// Clamped and error results then pass through the calc and finish states; interpolated
// results also start the divider and wait while it retires one quotient bit a cycle.
// Reset is synchronous, active low; the table contents are not cleared.
// A stalled result waits in the output register; one new request may be accepted meanwhile.
`timescale 1ns / 1ps

module piecewise_linear_calibration (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    // Configuration port.
    input  logic                                    i_cfg_we,
    input  logic [pwlc_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [pwlc_pkg::CFG_DATA_W-1:0]         i_cfg_data,
    // Request channel.
    input  logic                                    i_valid,
    output logic                                    o_stall,
    input  logic                                    i_req_type,
    input  logic [pwlc_pkg::INDEX_W-1:0]            i_entry_index,
    input  logic signed [pwlc_pkg::FIELD_W-1:0]     i_entry_raw,
    input  logic signed [pwlc_pkg::FIELD_W-1:0]     i_entry_reference,
    input  logic signed [pwlc_pkg::FIELD_W-1:0]     i_sample_raw,
    // Result channel.
    output logic                                    o_valid,
    input  logic                                    i_stall,
    output logic signed [pwlc_pkg::CORR_W-1:0]      o_corrected,
    output logic [pwlc_pkg::STATUS_W-1:0]           o_status
);

    import pwlc_pkg::*;

    t_state r_state;
    t_state n_state;

    // Configuration registers.
    logic [POINTS_W-1:0]        r_points;
    logic                       r_extrap;

    // Scan registers.
    logic [CNT_BITS-1:0]        r_n;
    logic [CNT_BITS-1:0]        r_rd_idx;
    logic [CNT_BITS-1:0]        r_cmp_idx;
    logic                       r_data_vld;
    logic signed [FIELD_W-1:0]  r_x;
    logic signed [FIELD_W-1:0]  r_prev_raw;
    logic signed [FIELD_W-1:0]  r_prev_ref;
    logic signed [FIELD_W-1:0]  r_a_raw;
    logic signed [FIELD_W-1:0]  r_a_ref;
    logic signed [FIELD_W-1:0]  r_b_raw;
    logic signed [FIELD_W-1:0]  r_b_ref;
    logic signed [FIELD_W-1:0]  r_ref0;
    logic signed [FIELD_W-1:0]  r_last_ref;
    logic                       r_found;
    logic                       r_bad;
    logic                       r_le0;
    logic                       r_ge_last;

    // Arithmetic registers.
    logic signed [PROD_W-1:0]   r_prod;
    logic [DIFF_W-1:0]          r_span;
    logic                       r_neg;

    // Pending result and output stage.
    logic signed [CORR_W-1:0]   r_res_corr;
    logic [STATUS_W-1:0]        r_res_status;
    logic                       r_out_valid;
    logic signed [CORR_W-1:0]   r_out_corr;
    logic [STATUS_W-1:0]        r_out_status;

    // Combinational signals.
    logic                       in_xfer;
    logic                       out_free;
    logic [CNT_BITS-1:0]        n_sat;
    logic                       few;
    logic                       ram_we;
    logic [IDX_BITS-1:0]        ram_addr;
    logic [ENTRY_W-1:0]         ram_wdata;
    logic [ENTRY_W-1:0]         ram_rdata;
    logic signed [FIELD_W-1:0]  cur_raw;
    logic signed [FIELD_W-1:0]  cur_ref;
    logic                       scan_last;
    logic                       rd_more;
    logic signed [DIFF_W-1:0]   dx;
    logic signed [DIFF_W-1:0]   dref;
    logic signed [DIFF_W-1:0]   span;
    logic signed [PROD_W-1:0]   prod;
    logic                       clamp_lo;
    logic                       clamp_hi;
    logic                       need_div;
    logic [PROD_W-1:0]          prod_mag;
    logic                       div_start;
    logic                       div_done;
    logic [DIV_BITS-1:0]        div_quo;
    logic signed [CORR_W-1:0]   quo_ext;
    logic signed [CORR_W-1:0]   interp;
    logic                       wr_in_range;

    assign in_xfer  = i_valid && !o_stall;
    assign out_free = !r_out_valid || !i_stall;

    // Point count saturated at the table capacity.
    assign n_sat = (32'(r_points) > 32'(MAX_POINTS)) ? CNT_BITS'(MAX_POINTS)
                                                     : CNT_BITS'(r_points);
    assign few   = 32'(n_sat) < 32'(MIN_POINTS);

    assign wr_in_range = 32'(i_entry_index) < 32'(MAX_POINTS);

    // Current table entry on the RAM read port.
    assign cur_raw   = ram_rdata[ENTRY_W-1:FIELD_W];
    assign cur_ref   = ram_rdata[FIELD_W-1:0];
    assign scan_last = r_data_vld && (r_cmp_idx == r_n - 1'b1);
    assign rd_more   = r_rd_idx < r_n;

    // Segment arithmetic.
    assign dx   = DIFF_W'(r_x) - DIFF_W'(r_a_raw);
    assign dref = DIFF_W'(r_b_ref) - DIFF_W'(r_a_ref);
    assign span = DIFF_W'(r_b_raw) - DIFF_W'(r_a_raw);
    assign prod = dx * dref;

    assign clamp_lo = !r_extrap && r_le0;
    assign clamp_hi = !r_extrap && r_ge_last;
    assign need_div = !r_bad && !clamp_lo && !clamp_hi && (span > 0);

    assign prod_mag = r_prod[PROD_W-1] ? PROD_W'(-r_prod) : PROD_W'(r_prod);
    assign quo_ext  = CORR_W'(div_quo);
    assign interp   = CORR_W'(r_a_ref) + (r_neg ? -quo_ext : quo_ext);

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_points <= '0;
            r_extrap <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_POINTS: r_points <= i_cfg_data[POINTS_W-1:0];
                CFG_EXTRAP: r_extrap <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    if (i_req_type == REQ_WRITE || few) begin
                        n_state = S_FINISH;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (scan_last) begin
                    n_state = S_CALC;
                end
            end
            S_CALC: begin
                n_state = need_div ? S_DIV_START : S_FINISH;
            end
            S_DIV_START: n_state = S_DIV_WAIT;
            S_DIV_WAIT: begin
                if (div_done) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs: request stall, RAM port and divider start.
    always_comb begin
        o_stall   = 1'b1;
        ram_we    = 1'b0;
        ram_addr  = IDX_BITS'(i_entry_index);
        ram_wdata = {sext_raw(i_entry_raw), i_entry_reference};
        div_start = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_stall = 1'b0;
                ram_we  = i_valid && (i_req_type == REQ_WRITE) && wr_in_range;
            end
            S_SCAN:      ram_addr  = r_rd_idx[IDX_BITS-1:0];
            S_DIV_START: div_start = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Scan control counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_idx   <= '0;
            r_cmp_idx  <= '0;
            r_data_vld <= 1'b0;
        end else if (r_state == S_SCAN) begin
            r_data_vld <= rd_more;
            if (rd_more) begin
                r_rd_idx <= r_rd_idx + 1'b1;
            end
            if (r_data_vld) begin
                r_cmp_idx <= r_cmp_idx + 1'b1;
            end
        end else begin
            r_rd_idx   <= '0;
            r_cmp_idx  <= '0;
            r_data_vld <= 1'b0;
        end
    end

    // Datapath: capture the request, walk the table, compute the result.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_n       <= n_sat;
                r_x       <= sext_raw(i_sample_raw);
                r_found   <= 1'b0;
                r_bad     <= 1'b0;
                r_res_corr   <= '0;
                r_res_status <= (i_req_type == REQ_CONVERT && few) ? ST_FEW : ST_OK;
            end
            S_SCAN: begin
                if (r_data_vld) begin
                    r_prev_raw <= cur_raw;
                    r_prev_ref <= cur_ref;
                    r_last_ref <= cur_ref;
                    if (r_cmp_idx == '0) begin
                        r_le0  <= r_x <= cur_raw;
                        r_ref0 <= cur_ref;
                    end else begin
                        // Raw points must rise strictly.
                        if (cur_raw <= r_prev_raw) begin
                            r_bad <= 1'b1;
                        end
                        // Keep the first segment that holds the sample, else the last one.
                        if (!r_found) begin
                            r_a_raw <= r_prev_raw;
                            r_a_ref <= r_prev_ref;
                            r_b_raw <= cur_raw;
                            r_b_ref <= cur_ref;
                            r_found <= r_x <= cur_raw;
                        end
                    end
                    if (scan_last) begin
                        r_ge_last <= r_x >= cur_raw;
                    end
                end
            end
            S_CALC: begin
                r_prod <= prod;
                r_span <= span;
                if (r_bad) begin
                    r_res_corr   <= '0;
                    r_res_status <= ST_NOT_RISING;
                end else if (clamp_lo) begin
                    r_res_corr   <= CORR_W'(r_ref0);
                    r_res_status <= ST_OK;
                end else if (clamp_hi) begin
                    r_res_corr   <= CORR_W'(r_last_ref);
                    r_res_status <= ST_OK;
                end else if (span > 0) begin
                    r_res_corr   <= '0;
                    r_res_status <= ST_OK;
                end else begin
                    r_res_corr   <= '0;
                    r_res_status <= ST_NUMERIC;
                end
            end
            S_DIV_START: begin
                r_neg <= r_prod[PROD_W-1];
            end
            S_DIV_WAIT: begin
                if (div_done) begin
                    r_res_corr <= interp;
                end
            end
            default: ;
        endcase
    end

    // Output register holds a result until it is transferred.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_FINISH && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_FINISH && out_free) begin
            r_out_corr   <= r_res_corr;
            r_out_status <= r_res_status;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_corrected = r_out_corr;
    assign o_status    = r_out_status;

    // Calibration table: raw point in the upper half, reference in the lower half.
    pwlc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_POINTS),
        .ADDR_W(IDX_BITS)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(ram_wdata),
        .o_rdata(ram_rdata)
    );

    // Serial divider for the segment quotient.
    pwlc_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_dividend(prod_mag[DIV_BITS-1:0]),
        .i_divisor (r_span),
        .o_done    (div_done),
        .o_quotient(div_quo)
    );

    // Error results always carry a zero value.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> (o_corrected == '0))
        else $error("error result with nonzero value");

    // The divider finishes only while the sequencer waits for it.
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV_WAIT))
        else $error("divider finished outside its wait state");

    // A scan runs only with enough points in use.
    a_scan_n: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (32'(r_n) >= 32'(MIN_POINTS)))
        else $error("scan started with too few points");

    // Compared entries stay inside the used part of the table.
    a_scan_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && r_data_vld) |-> (r_cmp_idx < r_n))
        else $error("scan compared an entry beyond the points in use");

endmodule
